[design/order0_bitwise_arithmetic_encoder_assert.svh]
// Assertion macros for the order-0 bitwise arithmetic encoder
`ifndef ORDER0_BITWISE_ARITHMETIC_ENCODER_ASSERT_SVH
`define ORDER0_BITWISE_ARITHMETIC_ENCODER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define O0BAE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define O0BAE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/o0bae_pkg.sv]
// Shared constants for the order-0 bitwise arithmetic encoder
package o0bae_pkg;

    localparam int COUNT_BITS_DEF = 16;
    localparam int CTX_DEPTH      = 512;
    localparam int CTX_BITS       = $clog2(CTX_DEPTH);
    localparam int PROB_BITS      = 12;
    localparam int RANGE_BITS     = 32;
    localparam int SPAN_BITS      = RANGE_BITS - PROB_BITS;
    localparam int MAX_OUT        = 20;
    localparam int OUT_CNT_BITS   = $clog2(MAX_OUT + 1);
    localparam int STEP_BITS      = $clog2(PROB_BITS);
    localparam int BIT_CNT_BITS   = 4;
    localparam int DATA_BITS      = 8;

endpackage

[design/o0bae_ram.sv]
// Generic single-write, single-read RAM with registered read data
module o0bae_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[design/order0_bitwise_arithmetic_encoder.sv]
// Order-0 bitwise binary arithmetic encoder: top level with sequencer and shared divider
//
//  channel | direction | tdata          | side fields
//  s_      | in        | data_byte[7:0] | tuser[0] = cmd (1 = end of stream)
//  m_      | out       | out_byte[7:0]  | tlast = last_of_run
//
//  Each coded bit goes through a context RAM read, a 12-step restoring divide for
//  the probability, one multiply, one range update and a settle step per settled
//  byte. A data byte is nine bits. After reset and after an end transaction a pass
//  over all 512 entries clears the count RAM; s_tready stays low during it. Output
//  stalls hold the sequencer when a byte has nowhere to go; one finished byte waits
//  in the output register.
module order0_bitwise_arithmetic_encoder
    import o0bae_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic [0:0] s_tuser,   // [0] cmd
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast
);

    localparam int CB = COUNT_BITS;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_READ, S_LOAD, S_DIV, S_MUL, S_UPD, S_SETTLE, S_FLUSH, S_DONE
    } state_t;

    state_t                  state_reg, state_next;
    logic [CTX_BITS-1:0]     clr_idx_reg, clr_idx_next;
    logic [CTX_BITS-1:0]     ctx_reg, ctx_next;
    logic                    cmd_reg, cmd_next;
    logic [DATA_BITS-1:0]    byte_reg, byte_next;
    logic [BIT_CNT_BITS-1:0] bit_cnt_reg, bit_cnt_next;
    logic [RANGE_BITS-1:0]   low_reg, low_next;
    logic [RANGE_BITS-1:0]   high_reg, high_next;
    logic [CB-1:0]           n0_reg, n0_next;
    logic [CB-1:0]           n1_reg, n1_next;
    logic [CB:0]             den_reg, den_next;
    logic [CB:0]             rem_reg, rem_next;
    logic [PROB_BITS-1:0]    q_reg, q_next;
    logic [STEP_BITS-1:0]    div_step_reg, div_step_next;
    logic [SPAN_BITS-1:0]    span_reg, span_next;
    logic [RANGE_BITS-1:0]   prod_reg, prod_next;
    logic [7:0]              pend_reg, pend_next;
    logic                    pend_valid_reg, pend_valid_next;
    logic [OUT_CNT_BITS-1:0] out_cnt_reg, out_cnt_next;
    logic                    out_valid_reg, out_valid_next;
    logic [7:0]              out_data_reg, out_data_next;
    logic                    out_last_reg, out_last_next;

    logic                    ram_we;
    logic [CTX_BITS-1:0]     ram_waddr;
    logic [2*CB-1:0]         ram_wdata;
    logic [2*CB-1:0]         ram_rdata;

    logic                    cur_bit;
    logic                    out_free;
    logic                    cap_hit;
    logic                    emit_go;
    logic [CB+1:0]           rem_sh;
    logic                    rem_ge;
    logic [RANGE_BITS-1:0]   mid;
    logic [RANGE_BITS-1:0]   diff;
    logic [CB-1:0]           n0_inc;
    logic [CB-1:0]           n1_inc;
    logic [CB-1:0]           n0_new;
    logic [CB-1:0]           n1_new;
    logic                    over;

    o0bae_ram #(
        .WIDTH(2 * CB),
        .DEPTH(CTX_DEPTH)
    ) u_counts (
        .clk  (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ctx_reg),
        .rdata(ram_rdata)
    );

    assign cur_bit  = (bit_cnt_reg == '0) ? cmd_reg : byte_reg[DATA_BITS-1];
    assign out_free = !out_valid_reg || m_tready;
    assign cap_hit  = (out_cnt_reg >= OUT_CNT_BITS'(MAX_OUT));
    assign emit_go  = cap_hit || !pend_valid_reg || out_free;
    assign rem_sh   = {rem_reg, 1'b0};
    assign rem_ge   = (rem_sh >= {1'b0, den_reg});
    assign mid      = low_reg + prod_reg;
    assign diff     = high_reg - low_reg;
    assign n0_inc   = n0_reg + CB'(1);
    assign n1_inc   = n1_reg + CB'(1);
    assign over     = cur_bit ? (&n1_inc) : (&n0_inc);

    always_comb begin
        n0_new = cur_bit ? n0_reg : n0_inc;
        n1_new = cur_bit ? n1_inc : n1_reg;
        if (over) begin
            n0_new = n0_new >> 1;
            n1_new = n1_new >> 1;
        end
    end

    always_comb begin
        state_next      = state_reg;
        clr_idx_next    = clr_idx_reg;
        ctx_next        = ctx_reg;
        cmd_next        = cmd_reg;
        byte_next       = byte_reg;
        bit_cnt_next    = bit_cnt_reg;
        low_next        = low_reg;
        high_next       = high_reg;
        n0_next         = n0_reg;
        n1_next         = n1_reg;
        den_next        = den_reg;
        rem_next        = rem_reg;
        q_next          = q_reg;
        div_step_next   = div_step_reg;
        span_next       = span_reg;
        prod_next       = prod_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        out_cnt_next    = out_cnt_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_data_next   = out_data_reg;
        out_last_next   = out_last_reg;
        ram_we          = 1'b0;
        ram_waddr       = ctx_reg;
        ram_wdata       = {n1_new, n0_new};

        unique case (state_reg)
            S_CLEAR: begin
                ram_we       = 1'b1;
                ram_waddr    = clr_idx_reg;
                ram_wdata    = '0;
                clr_idx_next = clr_idx_reg + CTX_BITS'(1);
                if (&clr_idx_reg) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd_next     = s_tuser[0];
                    byte_next    = s_tdata;
                    bit_cnt_next = '0;
                    ctx_next     = CTX_BITS'(1);
                    out_cnt_next = '0;
                    state_next   = S_READ;
                end
            end
            S_READ: begin
                state_next = S_LOAD;
            end
            S_LOAD: begin
                n0_next       = ram_rdata[CB-1:0];
                n1_next       = ram_rdata[2*CB-1:CB];
                den_next      = {1'b0, ram_rdata[CB-1:0]} + {1'b0, ram_rdata[2*CB-1:CB]}
                                + (CB+1)'(2);
                rem_next      = {1'b0, ram_rdata[2*CB-1:CB]} + (CB+1)'(1);
                q_next        = '0;
                div_step_next = '0;
                span_next     = diff[RANGE_BITS-1:PROB_BITS];
                state_next    = S_DIV;
            end
            S_DIV: begin
                q_next = {q_reg[PROB_BITS-2:0], rem_ge};
                if (rem_ge) begin
                    rem_next = (CB+1)'(rem_sh - {1'b0, den_reg});
                end else begin
                    rem_next = rem_sh[CB:0];
                end
                div_step_next = div_step_reg + STEP_BITS'(1);
                if (div_step_reg == STEP_BITS'(PROB_BITS - 1)) begin
                    state_next = S_MUL;
                end
            end
            S_MUL: begin
                prod_next  = RANGE_BITS'(span_reg) * RANGE_BITS'(q_reg);
                state_next = S_UPD;
            end
            S_UPD: begin
                if (cur_bit) begin
                    high_next = mid;
                end else begin
                    low_next = mid + RANGE_BITS'(1);
                end
                ram_we     = 1'b1;
                state_next = S_SETTLE;
            end
            S_SETTLE: begin
                if (low_reg[31:24] == high_reg[31:24]) begin
                    if (emit_go) begin
                        if (!cap_hit) begin
                            if (pend_valid_reg) begin
                                out_valid_next = 1'b1;
                                out_data_next  = pend_reg;
                                out_last_next  = 1'b0;
                            end
                            pend_next       = high_reg[31:24];
                            pend_valid_next = 1'b1;
                            out_cnt_next    = out_cnt_reg + OUT_CNT_BITS'(1);
                        end
                        low_next  = {low_reg[23:0], 8'h00};
                        high_next = {high_reg[23:0], 8'hff};
                    end
                end else if (cmd_reg) begin
                    state_next = S_FLUSH;
                end else if (bit_cnt_reg == BIT_CNT_BITS'(DATA_BITS)) begin
                    state_next = S_DONE;
                end else begin
                    if (bit_cnt_reg != '0) begin
                        byte_next = {byte_reg[DATA_BITS-2:0], 1'b0};
                    end
                    bit_cnt_next = bit_cnt_reg + BIT_CNT_BITS'(1);
                    ctx_next     = {ctx_reg[CTX_BITS-2:0], cur_bit};
                    state_next   = S_READ;
                end
            end
            S_FLUSH: begin
                if (emit_go) begin
                    if (!cap_hit) begin
                        if (pend_valid_reg) begin
                            out_valid_next = 1'b1;
                            out_data_next  = pend_reg;
                            out_last_next  = 1'b0;
                        end
                        pend_next       = high_reg[31:24];
                        pend_valid_next = 1'b1;
                        out_cnt_next    = out_cnt_reg + OUT_CNT_BITS'(1);
                    end
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (!pend_valid_reg || out_free) begin
                    if (pend_valid_reg) begin
                        out_valid_next  = 1'b1;
                        out_data_next   = pend_reg;
                        out_last_next   = 1'b1;
                        pend_valid_next = 1'b0;
                    end
                    out_cnt_next = '0;
                    if (cmd_reg) begin
                        low_next     = '0;
                        high_next    = '1;
                        clr_idx_next = '0;
                        state_next   = S_CLEAR;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_CLEAR;
            clr_idx_reg    <= '0;
            low_reg        <= '0;
            high_reg       <= '1;
            pend_valid_reg <= 1'b0;
            out_cnt_reg    <= '0;
            out_valid_reg  <= 1'b0;
            bit_cnt_reg    <= '0;
            div_step_reg   <= '0;
        end else begin
            state_reg      <= state_next;
            clr_idx_reg    <= clr_idx_next;
            low_reg        <= low_next;
            high_reg       <= high_next;
            pend_valid_reg <= pend_valid_next;
            out_cnt_reg    <= out_cnt_next;
            out_valid_reg  <= out_valid_next;
            bit_cnt_reg    <= bit_cnt_next;
            div_step_reg   <= div_step_next;
        end
        ctx_reg      <= ctx_next;
        cmd_reg      <= cmd_next;
        byte_reg     <= byte_next;
        n0_reg       <= n0_next;
        n1_reg       <= n1_next;
        den_reg      <= den_next;
        rem_reg      <= rem_next;
        q_reg        <= q_next;
        span_reg     <= span_next;
        prod_reg     <= prod_next;
        pend_reg     <= pend_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

`include "order0_bitwise_arithmetic_encoder_assert.svh"

    `O0BAE_ASSERT_NOW(a_idle_clean, s_tready, !pend_valid_reg && out_cnt_reg == '0, "idle with pending byte")
    `O0BAE_ASSERT_NOW(a_cnt_cap, 1'b1, out_cnt_reg <= OUT_CNT_BITS'(MAX_OUT), "output count past cap")
    `O0BAE_ASSERT_NOW(a_div_bound, state_reg == S_DIV, div_step_reg < STEP_BITS'(PROB_BITS), "divider overran")
    `O0BAE_ASSERT_NEXT(a_accept_read, s_tvalid && s_tready, state_reg == S_READ, "transaction not started")

endmodule
